>>> rtl/fnpdp_pkg.sv
// Package for the fractional-N PLL divider planner: widths, band and track tables,
// configuration register indexes and the structs that travel down the pipeline.
// Depends on nothing; used by frac_n_pll_divider_planner.
package fnpdp_pkg;

  localparam int unsigned FREQ_W   = 32;
  localparam int unsigned X_W      = 26;
  localparam int unsigned MULT_W   = 7;
  localparam int unsigned FVCO_W   = FREQ_W + MULT_W;
  localparam int unsigned FRAC_W   = 15;
  localparam int unsigned DIV_BITS = FVCO_W + FRAC_W;
  localparam int unsigned XDIV_W   = 16;
  localparam int unsigned QKEEP_W  = XDIV_W + FRAC_W;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned PROD_W   = 58;
  localparam int unsigned ACT_W    = PROD_W - FRAC_W;
  localparam int unsigned DIFF_W   = 44;
  localparam int unsigned T_W      = 25;
  localparam int unsigned ERR_W    = 24;
  localparam int unsigned RECIP_SH = 26;

  // Reciprocal of three scaled by two to the 26th, rounded up.
  localparam logic [T_W-1:0] RECIP_3 = 25'd22369622;

  localparam logic [ERR_W-1:0] ERR_POS_MAX = 24'h7FFFFF;
  localparam logic [ERR_W-1:0] ERR_NEG_MIN = 24'h800000;
  localparam logic [T_W-1:0]   MAG_POS_MAX = 25'd8388607;
  localparam logic [T_W-1:0]   MAG_NEG_MAX = 25'd8388608;

  localparam logic [FREQ_W-1:0] F_UHF     = 32'd300000000;
  localparam logic [FREQ_W-1:0] F_X2_EDGE = 32'd948600000;
  localparam logic [FVCO_W-1:0] VCO_HIGH  = 39'd3060000000;

  localparam logic [FREQ_W-1:0] BAND_EDGE [0:8] = '{
    32'd37084000,  32'd55625000,  32'd74167000,
    32'd111250000, 32'd148334000, 32'd222500000,
    32'd296667000, 32'd445000000, 32'd593334000
  };

  localparam logic [FREQ_W-1:0] TRACK_EDGE [0:5] = '{
    32'd177500000, 32'd184500000, 32'd191500000,
    32'd198500000, 32'd205500000, 32'd219500000
  };

  localparam logic [7:0] DIV_LOW_BITS = 8'h07;
  localparam logic [7:0] A_MAX        = 8'd15;
  localparam logic [7:0] M_MIN        = 8'h0b;
  localparam logic [7:0] M_CLAMP      = 8'd31;

  localparam logic [X_W-1:0] XTAL_RESET = 26'd14400000;
  localparam logic [1:0]     BW_RESET   = 2'd2;

  typedef enum logic [1:0] {
    CFG_CHIP_VARIANT = 2'd0,
    CFG_XTAL_HALF_HZ = 2'd1,
    CFG_BANDWIDTH    = 2'd2
  } cfg_idx_t;

  // Band index: 0..8 from the edge table, 9 is the x4 band, 10 the x2 band.
  typedef logic [3:0] band_t;

  localparam band_t BAND_X64 = 4'd1;
  localparam band_t BAND_X4  = 4'd9;
  localparam band_t BAND_X2  = 4'd10;

  // Per-item controls that are settled from the frequency and the chip variant.
  typedef struct packed {
    band_t      band;
    logic [2:0] track;
    logic       uhf;
    logic       gpio;
    logic       mix64;
  } side_t;

  // Controls that travel down the error tail after the divider.
  typedef struct packed {
    side_t             sd;
    logic              vco_hi;
    logic [XDIV_W-1:0] xdiv;
    logic [FRAC_W-1:0] xin;
  } tail_t;

  function automatic logic [MULT_W-1:0] band_mult(input band_t b);
    logic [MULT_W-1:0] m;
    unique case (b)
      4'd0:    m = 7'd96;
      4'd1:    m = 7'd64;
      4'd2:    m = 7'd48;
      4'd3:    m = 7'd32;
      4'd4:    m = 7'd24;
      4'd5:    m = 7'd16;
      4'd6:    m = 7'd12;
      4'd7:    m = 7'd8;
      4'd8:    m = 7'd6;
      4'd9:    m = 7'd4;
      default: m = 7'd2;
    endcase
    return m;
  endfunction

  // Multiple is three times a power of two, or a power of two; this is the power.
  function automatic logic [2:0] band_shift(input band_t b);
    logic [2:0] s;
    unique case (b)
      4'd0:    s = 3'd5;
      4'd1:    s = 3'd6;
      4'd2:    s = 3'd4;
      4'd3:    s = 3'd5;
      4'd4:    s = 3'd3;
      4'd5:    s = 3'd4;
      4'd6:    s = 3'd2;
      4'd7:    s = 3'd3;
      4'd8:    s = 3'd1;
      4'd9:    s = 3'd2;
      default: s = 3'd1;
    endcase
    return s;
  endfunction

  function automatic logic band_div3(input band_t b);
    return (b <= 4'd8) && !b[0];
  endfunction

  function automatic logic [7:0] band_code(input band_t b, input logic var_b);
    logic [7:0] c;
    unique case (b)
      4'd0:    c = 8'h82;
      4'd1:    c = var_b ? 8'h02 : 8'h82;
      4'd2:    c = 8'h42;
      4'd3:    c = var_b ? 8'h82 : 8'h42;
      4'd4:    c = 8'h22;
      4'd5:    c = var_b ? 8'h42 : 8'h22;
      4'd6:    c = 8'h12;
      4'd7:    c = var_b ? 8'h22 : 8'h12;
      4'd8:    c = 8'h0a;
      4'd9:    c = var_b ? 8'h12 : 8'h0a;
      default: c = 8'h0a;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/frac_n_pll_divider_planner.sv
// Fractional-N PLL divider planner: one frequency in, one divider plan out per cycle.
// Throughput one item per cycle; busy stays low.
// The depth is set by the 54-stage restoring divider, one quotient bit per stage.
// Synchronous active-low reset clears valid bits and loads register defaults.
// Uses fnpdp_pkg.
module frac_n_pll_divider_planner
  import fnpdp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [31:0]       in_freq_hz,
  output logic              out_valid,
  output logic [7:0]        out_count9_cycles,
  output logic [7:0]        out_total_cycles,
  output logic [7:0]        out_frac_high,
  output logic [7:0]        out_frac_low,
  output logic [7:0]        out_divider_ctrl,
  output logic [7:0]        out_vco_ctrl,
  output logic              out_pll_invalid,
  output logic signed [23:0] out_rf_offset,
  output logic [2:0]        out_track_code,
  output logic              out_band_uhf,
  output logic              out_band_gpio,
  output logic              out_mix_x64,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int unsigned LATENCY = DIV_BITS + 8;

  // Configuration registers; a zero crystal value is kept as one.
  logic           variant_r;
  logic [X_W-1:0] xtal_r;
  logic [1:0]     bw_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= 1'b0;
      xtal_r    <= XTAL_RESET;
      bw_r      <= BW_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CHIP_VARIANT: variant_r <= cfg_data[0];
        CFG_XTAL_HALF_HZ: begin
          xtal_r <= (cfg_data[X_W-1:0] == '0) ? X_W'(1) : cfg_data[X_W-1:0];
        end
        CFG_BANDWIDTH:    bw_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: band pick and the per-frequency controls.
  logic              s1_valid_r;
  logic [FREQ_W-1:0] s1_freq_r;
  side_t             s1_sd_r;
  side_t             s1_sd_nxt;

  always_comb begin
    s1_sd_nxt.band = (variant_r && (in_freq_hz >= F_X2_EDGE)) ? BAND_X2 : BAND_X4;
    for (int i = 8; i >= 0; i--) begin
      if (in_freq_hz < BAND_EDGE[i]) begin
        s1_sd_nxt.band = band_t'(i);
      end
    end
    s1_sd_nxt.track = 3'd1;
    for (int i = 5; i >= 0; i--) begin
      if (in_freq_hz <= TRACK_EDGE[i]) begin
        s1_sd_nxt.track = 3'(7 - i);
      end
    end
    if (in_freq_hz >= F_UHF) begin
      s1_sd_nxt.track = 3'd7;
    end
    if (!variant_r) begin
      s1_sd_nxt.track = 3'd0;
    end
    s1_sd_nxt.uhf   = variant_r && (in_freq_hz >= F_UHF);
    s1_sd_nxt.gpio  = !variant_r && (in_freq_hz > F_UHF);
    s1_sd_nxt.mix64 = variant_r && (s1_sd_nxt.band == BAND_X64);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start;
    end
    s1_freq_r <= in_freq_hz;
    s1_sd_r   <= s1_sd_nxt;
  end

  // Divider pipeline: entry 0 holds the VCO product, entry i the state after i bits.
  logic               dv_valid_r [0:DIV_BITS];
  logic [X_W-1:0]     dv_rem_r   [0:DIV_BITS];
  logic [QKEEP_W-1:0] dv_q_r     [0:DIV_BITS];
  logic [FVCO_W-1:0]  dv_fvco_r  [0:DIV_BITS];
  side_t              dv_sd_r    [0:DIV_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r[0] <= 1'b0;
    end else begin
      dv_valid_r[0] <= s1_valid_r;
    end
    dv_rem_r[0]  <= '0;
    dv_q_r[0]    <= '0;
    dv_fvco_r[0] <= FVCO_W'(s1_freq_r * band_mult(s1_sd_r.band));
    dv_sd_r[0]   <= s1_sd_r;
  end

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
    logic             dbit;
    logic [X_W+1:0]   trial;
    logic [X_W-1:0]   rem_nxt;
    logic             qbit;

    // Dividend is the VCO product followed by fifteen zero fraction bits.
    if (i < FVCO_W) begin : g_bit
      assign dbit = dv_fvco_r[i][FVCO_W-1-i];
    end else begin : g_zero
      assign dbit = 1'b0;
    end

    // One restoring step: shift in a dividend bit, subtract when it fits.
    always_comb begin
      trial   = {1'b0, dv_rem_r[i], dbit} - {2'b00, xtal_r};
      qbit    = !trial[X_W+1];
      rem_nxt = qbit ? trial[X_W-1:0] : {dv_rem_r[i][X_W-2:0], dbit};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[i+1] <= 1'b0;
      end else begin
        dv_valid_r[i+1] <= dv_valid_r[i];
      end
      dv_rem_r[i+1]  <= rem_nxt;
      dv_q_r[i+1]    <= {dv_q_r[i][QKEEP_W-2:0], qbit};
      dv_fvco_r[i+1] <= dv_fvco_r[i];
      dv_sd_r[i+1]   <= dv_sd_r[i];
    end
  end

  // E1: rounded divider, signed fraction and the achieved-VCO product.
  logic [QKEEP_W-1:0]       q_end;
  logic [XDIV_W-1:0]        e1_xdiv_nxt;
  logic signed [SUM_W-1:0]  e1_sum;
  logic signed [PROD_W:0]   e1_prod_full;
  logic                     e1_valid_r;
  logic signed [PROD_W-1:0] e1_prod_r;
  logic [FVCO_W-1:0]        e1_fvco_r;
  tail_t                    e1_tl_r;

  always_comb begin
    q_end        = dv_q_r[DIV_BITS];
    // Fraction bit 14 set means twice the remainder reached the crystal value.
    e1_xdiv_nxt  = q_end[QKEEP_W-1:FRAC_W] + XDIV_W'(q_end[FRAC_W-1]);
    e1_sum       = $signed({1'b0, e1_xdiv_nxt, {FRAC_W{1'b0}}})
                 + $signed({{(SUM_W-FRAC_W){q_end[FRAC_W-1]}}, q_end[FRAC_W-1:0]});
    e1_prod_full = $signed({1'b0, xtal_r}) * e1_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_valid_r <= 1'b0;
    end else begin
      e1_valid_r <= dv_valid_r[DIV_BITS];
    end
    e1_prod_r      <= e1_prod_full[PROD_W-1:0];
    e1_fvco_r      <= dv_fvco_r[DIV_BITS];
    e1_tl_r.sd     <= dv_sd_r[DIV_BITS];
    e1_tl_r.vco_hi <= dv_fvco_r[DIV_BITS] >= VCO_HIGH;
    e1_tl_r.xdiv   <= e1_xdiv_nxt;
    e1_tl_r.xin    <= q_end[FRAC_W-1:0];
  end

  // E2: achieved VCO, the product over 32768 truncated toward zero.
  logic signed [PROD_W-1:0] e2_adj;
  logic                     e2_valid_r;
  logic signed [ACT_W-1:0]  e2_act_r;
  logic [FVCO_W-1:0]        e2_fvco_r;
  tail_t                    e2_tl_r;

  assign e2_adj = e1_prod_r + (e1_prod_r[PROD_W-1] ? PROD_W'(32767) : PROD_W'(0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e2_valid_r <= 1'b0;
    end else begin
      e2_valid_r <= e1_valid_r;
    end
    e2_act_r  <= e2_adj[PROD_W-1:FRAC_W];
    e2_fvco_r <= e1_fvco_r;
    e2_tl_r   <= e1_tl_r;
  end

  // E3: signed difference between requested and achieved VCO.
  logic                     e3_valid_r;
  logic signed [DIFF_W-1:0] e3_diff_r;
  tail_t                    e3_tl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e3_valid_r <= 1'b0;
    end else begin
      e3_valid_r <= e2_valid_r;
    end
    e3_diff_r <= $signed({{(DIFF_W-FVCO_W){1'b0}}, e2_fvco_r})
               - $signed({e2_act_r[ACT_W-1], e2_act_r});
    e3_tl_r   <= e2_tl_r;
  end

  // E4: magnitude, power-of-two part of the multiple, overflow check.
  logic [DIFF_W-1:0] e4_mag;
  logic [DIFF_W-1:0] e4_shr;
  logic              e4_valid_r;
  logic              e4_neg_r;
  logic              e4_big_r;
  logic [T_W-1:0]    e4_t_r;
  tail_t             e4_tl_r;

  always_comb begin
    e4_mag = e3_diff_r[DIFF_W-1] ? DIFF_W'(-e3_diff_r) : DIFF_W'(e3_diff_r);
    e4_shr = e4_mag >> band_shift(e3_tl_r.sd.band);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e4_valid_r <= 1'b0;
    end else begin
      e4_valid_r <= e3_valid_r;
    end
    e4_neg_r <= e3_diff_r[DIFF_W-1];
    e4_big_r <= |e4_shr[DIFF_W-1:T_W];
    e4_t_r   <= e4_shr[T_W-1:0];
    e4_tl_r  <= e3_tl_r;
  end

  // E5: reciprocal multiply for the factor of three.
  logic                   e5_valid_r;
  logic                   e5_neg_r;
  logic                   e5_big_r;
  logic [T_W-1:0]         e5_t_r;
  logic [2*T_W-1:0]       e5_prod_r;
  tail_t                  e5_tl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e5_valid_r <= 1'b0;
    end else begin
      e5_valid_r <= e4_valid_r;
    end
    e5_neg_r  <= e4_neg_r;
    e5_big_r  <= e4_big_r;
    e5_t_r    <= e4_t_r;
    e5_prod_r <= e4_t_r * RECIP_3;
    e5_tl_r   <= e4_tl_r;
  end

  // Output stage: saturate the error, split A and M counts, pack control bytes.
  logic [T_W-1:0]   mag_q;
  logic [ERR_W-1:0] err_nxt;
  logic [3:0]       am;
  logic [7:0]       pm;
  logic [7:0]       pm_over;
  logic [7:0]       a_nxt;
  logic [7:0]       m_nxt;
  logic             div3;

  always_comb begin
    div3  = band_div3(e5_tl_r.sd.band);
    mag_q = div3 ? {1'b0, e5_prod_r[2*T_W-1:RECIP_SH]} : e5_t_r;
    if (e5_neg_r) begin
      err_nxt = (e5_big_r || mag_q > MAG_NEG_MAX) ? ERR_NEG_MIN : ERR_W'(-mag_q);
    end else begin
      err_nxt = (e5_big_r || mag_q > MAG_POS_MAX) ? ERR_POS_MAX : mag_q[ERR_W-1:0];
    end

    pm = e5_tl_r.xdiv[10:3];
    am = {1'b0, e5_tl_r.xdiv[2:0]};
    if (am < 4'd2) begin
      am = am + 4'd8;
      pm = pm - 8'd1;
    end
    pm_over = pm - M_CLAMP;
    if (pm > M_CLAMP) begin
      a_nxt = {4'b0000, am} + {pm_over[4:0], 3'b000};
      m_nxt = M_CLAMP;
    end else begin
      a_nxt = {4'b0000, am};
      m_nxt = pm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= e5_valid_r;
    end
    out_count9_cycles <= a_nxt;
    out_total_cycles  <= m_nxt;
    out_frac_high     <= {e5_tl_r.xin[FRAC_W-1], e5_tl_r.xin[FRAC_W-1:8]};
    out_frac_low      <= e5_tl_r.xin[7:0];
    out_divider_ctrl  <= band_code(e5_tl_r.sd.band, variant_r) | DIV_LOW_BITS;
    out_vco_ctrl      <= {bw_r, 1'b1, 1'b0, e5_tl_r.vco_hi, 1'b0, !div3, 1'b0};
    out_pll_invalid   <= (a_nxt > A_MAX) || (m_nxt < M_MIN);
    out_rf_offset     <= $signed(err_nxt);
    out_track_code    <= e5_tl_r.sd.track;
    out_band_uhf      <= e5_tl_r.sd.uhf;
    out_band_gpio     <= e5_tl_r.sd.gpio;
    out_mix_x64       <= e5_tl_r.sd.mix64;
  end

  // Every accepted item yields its result after the fixed pipeline depth.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result strobe missing after pipeline latency");

  // A result with no item accepted that many cycles before is invented.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result strobe without a matching item");

  // The M count is clamped, so a larger value means the split went wrong.
  a_m_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_total_cycles <= M_CLAMP))
    else $error("M count above clamp");

  // Variant-specific controls never mix.
  a_variant_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_band_gpio) |->
      (!out_band_uhf && !out_mix_x64 && (out_track_code == 3'd0)))
    else $error("controls of both variants active");

endmodule

>>> tb/frac_n_pll_divider_planner_test.sv
// Testbench for the fractional-N PLL divider planner: drives frequencies and register
// writes, predicts each divider plan and checks every result field by field.
// Depends on fnpdp_pkg and frac_n_pll_divider_planner.
module frac_n_pll_divider_planner_test;
  import fnpdp_pkg::*;

  // One divider plan as the block reports it.
  typedef struct packed {
    logic [7:0]  a_cnt;
    logic [7:0]  m_cnt;
    logic [7:0]  frac_hi;
    logic [7:0]  frac_lo;
    logic [7:0]  div_code;
    logic [7:0]  vco;
    logic        invalid;
    logic [23:0] err;
    logic [2:0]  track;
    logic        uhf;
    logic        gpio;
    logic        mix64;
  } plan_t;

  // Scoreboard: computes the plan of each accepted frequency and matches results in order.
  class plan_scoreboard;
    plan_t pending[$];
    int    fails;
    bit    variant_b;
    logic [25:0] xtal_half;
    logic [1:0]  bw;

    function new();
      fails = 0;
      variant_b = 0;
      xtal_half = 26'd14400000;
      bw = 2'd2;
    endfunction

    function automatic plan_t plan_of(logic [31:0] f);
      plan_t p;
      longint unsigned x, fvco, q, rem;
      longint xin, act, err;
      int unsigned mult, code, pm, am, xdiv;
      int idx;
      x = (xtal_half == 0) ? 64'd1 : 64'(xtal_half);
      idx = 9;
      for (int i = 8; i >= 0; i--)
        if (f < BAND_EDGE[i]) idx = i;
      if (idx < 9) begin
        mult = 96 >> 0;
        case (idx)
          0: mult = 96; 1: mult = 64; 2: mult = 48; 3: mult = 32; 4: mult = 24;
          5: mult = 16; 6: mult = 12; 7: mult = 8; default: mult = 6;
        endcase
        case (idx)
          0: code = 'h82; 1: code = variant_b ? 'h02 : 'h82; 2: code = 'h42;
          3: code = variant_b ? 'h82 : 'h42; 4: code = 'h22;
          5: code = variant_b ? 'h42 : 'h22; 6: code = 'h12;
          7: code = variant_b ? 'h22 : 'h12; default: code = 'h0a;
        endcase
      end else if (!variant_b) begin
        mult = 4; code = 'h0a;
      end else if (f < F_X2_EDGE) begin
        mult = 4; code = 'h12;
      end else begin
        mult = 2; code = 'h0a;
      end
      fvco = 64'(f) * mult;
      p.vco = (mult % 3 == 0) ? 8'h00 : 8'h02;
      if (fvco >= 64'd3060000000) p.vco |= 8'h08;
      p.vco |= 8'h20 | {bw, 6'd0};
      q = fvco / x;
      rem = fvco - q * x;
      if (2 * rem >= x) q++;
      xdiv = 32'(q & 64'hFFFF);
      pm = (xdiv >> 3) & 'hFF;
      am = xdiv & 7;
      if (am < 2) begin
        am += 8;
        pm = (pm - 1) & 'hFF;
      end
      if (pm > 31) begin
        p.a_cnt = 8'(am + 8 * (pm - 31));
        p.m_cnt = 8'd31;
      end else begin
        p.a_cnt = 8'(am);
        p.m_cnt = 8'(pm);
      end
      xin = longint'((rem << 15) / x);
      if (xin >= 16384) xin -= 32768;
      act = (longint'(x) * longint'(xdiv) * 32768 + longint'(x) * xin) / 32768;
      err = (longint'(fvco) - act) / longint'(mult);
      if (err > 8388607) err = 8388607;
      if (err < -8388608) err = -8388608;
      p.frac_hi = xin[15:8];
      p.frac_lo = xin[7:0];
      p.div_code = 8'(code) | 8'h07;
      p.invalid = (p.a_cnt > 15) || (p.m_cnt < 11);
      p.err = err[23:0];
      p.track = 3'd0;
      if (variant_b) begin
        if (f >= F_UHF) p.track = 3'd7;
        else begin
          p.track = 3'd1;
          for (int i = 5; i >= 0; i--)
            if (f <= TRACK_EDGE[i]) p.track = 3'(7 - i);
        end
      end
      p.uhf = variant_b && (f >= F_UHF);
      p.gpio = !variant_b && (f > F_UHF);
      p.mix64 = variant_b && (mult == 64);
      return p;
    endfunction

    function void note_freq(logic [31:0] f);
      pending.push_back(plan_of(f));
    endfunction

    function void check_plan(plan_t got);
      plan_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fails++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        fails++;
        if (got.a_cnt !== want.a_cnt)
          $display("%0t: A count exp %h got %h", $time, want.a_cnt, got.a_cnt);
        if (got.m_cnt !== want.m_cnt)
          $display("%0t: M count exp %h got %h", $time, want.m_cnt, got.m_cnt);
        if (got.frac_hi !== want.frac_hi)
          $display("%0t: frac_high exp %h got %h", $time, want.frac_hi, got.frac_hi);
        if (got.frac_lo !== want.frac_lo)
          $display("%0t: frac_low exp %h got %h", $time, want.frac_lo, got.frac_lo);
        if (got.div_code !== want.div_code)
          $display("%0t: divider_ctrl exp %h got %h", $time, want.div_code, got.div_code);
        if (got.vco !== want.vco)
          $display("%0t: vco_ctrl exp %h got %h", $time, want.vco, got.vco);
        if (got.invalid !== want.invalid)
          $display("%0t: pll_invalid exp %b got %b", $time, want.invalid, got.invalid);
        if (got.err !== want.err)
          $display("%0t: rf_offset exp %h got %h", $time, want.err, got.err);
        if (got.track !== want.track)
          $display("%0t: track_code exp %h got %h", $time, want.track, got.track);
        if (got.uhf !== want.uhf)
          $display("%0t: band_uhf exp %b got %b", $time, want.uhf, got.uhf);
        if (got.gpio !== want.gpio)
          $display("%0t: band_gpio exp %b got %b", $time, want.gpio, got.gpio);
        if (got.mix64 !== want.mix64)
          $display("%0t: mix_x64 exp %b got %b", $time, want.mix64, got.mix64);
      end
    endfunction
  endclass

  localparam int LATENCY = 62;
  localparam int STALL_LIMIT = 2000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [31:0] in_freq_hz = '0;
  logic        out_valid;
  logic [7:0]  out_count9_cycles, out_total_cycles, out_frac_high, out_frac_low;
  logic [7:0]  out_divider_ctrl, out_vco_ctrl;
  logic        out_pll_invalid;
  logic signed [23:0] out_rf_offset;
  logic [2:0]  out_track_code;
  logic        out_band_uhf, out_band_gpio, out_mix_x64;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          idle_cycles = 0;

  plan_scoreboard board = new();

  frac_n_pll_divider_planner uut (.*);

  always #5 clk = ~clk;

  // Check each result strobe and count cycles in which nothing moves.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      board.check_plan({out_count9_cycles, out_total_cycles, out_frac_high, out_frac_low,
                        out_divider_ctrl, out_vco_ctrl, out_pll_invalid, out_rf_offset,
                        out_track_code, out_band_uhf, out_band_gpio, out_mix_x64});
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Write one register, keeping the local copy in step.
  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      CFG_CHIP_VARIANT: board.variant_b = value[0];
      CFG_XTAL_HALF_HZ: board.xtal_half = value[25:0];
      default:          board.bw = value[1:0];
    endcase
    // A wait with cfg_valid low keeps the next write from landing in the same step.
    @(posedge clk);
  endtask

  // Wait until every expected plan has come back, then let the pipeline drain.
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Offer one frequency; start stays high across back-to-back items.
  task automatic send_freq(logic [31:0] f);
    start <= 1;
    in_freq_hz <= f;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_freq(f);
  endtask

  // Random frequency: mostly near band and track edges or in the tuning range.
  function automatic logic [31:0] pick_freq();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return BAND_EDGE[$urandom_range(0, 8)] + $urandom_range(0, 4) - 2;
    if (sel == 3) return TRACK_EDGE[$urandom_range(0, 5)] + $urandom_range(0, 4) - 2;
    if (sel == 4) return F_UHF + $urandom_range(0, 2) - 1;
    if (sel == 5) return $urandom();
    return $urandom_range(0, 1800000000);
  endfunction

  // Random burst of items with random gaps.
  task automatic run_bursts(int count);
    int n;
    n = 0;
    while (n < count) begin
      for (int i = $urandom_range(1, 20); i > 0 && n < count; i--) begin
        send_freq(pick_freq());
        n++;
      end
      if ($urandom_range(0, 2) != 0) begin
        start <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  initial begin
    logic [31:0] directed[$];
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed frequencies at reset settings, then under the second variant.
    directed = '{32'd0, 32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA, 32'd37083999,
                 32'd37084000, 32'd55625000, 32'd177500000, 32'd219500001,
                 32'd299999999, 32'd300000000, 32'd300000001, 32'd593334000,
                 32'd948599999, 32'd948600000, 32'd1530000000, 32'd100000000};
    foreach (directed[i]) send_freq(directed[i]);
    drain();
    write_reg(CFG_CHIP_VARIANT, 32'd1);
    write_reg(CFG_BANDWIDTH, 32'd3);
    foreach (directed[i]) send_freq(directed[i]);
    drain();

    // Crystal extremes and an unset crystal.
    write_reg(CFG_XTAL_HALF_HZ, 32'd0);
    send_freq(32'd100000000);
    send_freq(32'hFFFFFFFF);
    drain();
    write_reg(CFG_XTAL_HALF_HZ, 32'h03FFFFFF);
    write_reg(CFG_BANDWIDTH, 32'd0);
    send_freq(32'd0);
    send_freq(32'hFFFFFFFF);
    drain();

    // Random phases over several settings.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_CHIP_VARIANT, $urandom_range(0, 1));
      case (ph)
        0: write_reg(CFG_XTAL_HALF_HZ, 32'd1000000);
        1: write_reg(CFG_XTAL_HALF_HZ, 32'd40000000);
        2: write_reg(CFG_XTAL_HALF_HZ, 32'd14400000);
        default: write_reg(CFG_XTAL_HALF_HZ, $urandom());
      endcase
      write_reg(CFG_BANDWIDTH, $urandom_range(0, 3));
      run_bursts(180);
      drain();
    end

    if (board.fails == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

>>> filelist.f
rtl/fnpdp_pkg.sv
rtl/frac_n_pll_divider_planner.sv
tb/frac_n_pll_divider_planner_test.sv
